// File: hdl/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types, constants and helpers for the shelf atlas allocator.
// ----------------------------------------------------------------------------
package asa_pkg;

  typedef struct packed {
    logic [14:0] req_width;
    logic [14:0] req_height;
  } asa_in_t;

  typedef struct packed {
    logic [13:0] place_x;
    logic [13:0] place_y;
    logic [14:0] place_width;
    logic [14:0] place_height;
    logic [14:0] atlas_width;
    logic [14:0] atlas_height;
    logic        grew;
    logic [1:0]  status;
  } asa_out_t;

  typedef struct packed {
    logic [14:0] left_x;
    logic [14:0] top_y;
    logic [14:0] space;
    logic [14:0] tall;
  } asa_row_t;

  typedef struct packed {
    logic        valid;
    logic [14:0] rw;
    logic [14:0] rh;
  } asa_probe_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GROW,
    ST_COMMIT,
    ST_OUT
  } asa_state_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SIDE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // smallest power of two at or above v, at most 2^15 for any 15-bit input
  function automatic logic [16:0] pow2_ceil(input logic [14:0] v);
    logic [16:0] p;
    p = 17'd1;
    for (int k = 0; k < 16; k++) begin
      if (p < {2'b00, v}) p = p << 1;
    end
    return p;
  endfunction

endpackage

// File: hdl/asa_cell.sv
// ----------------------------------------------------------------------------
// asa_cell
// One row slot: holds a row, forwards the probe and the first-fit hit flag.
// ----------------------------------------------------------------------------
module asa_cell
  import asa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       occ_set,
  input  logic       clr_all,
  input  logic       wr_en,
  input  asa_row_t   wr_row,
  input  logic       upd_en,
  input  logic [14:0] upd_w,
  input  asa_probe_t probe_in,
  input  logic       hit_in,
  output asa_probe_t probe_out,
  output logic       hit_out,
  output logic       mine,
  output asa_row_t   row
);

  logic     occ_r;
  asa_row_t row_r;
  asa_probe_t probe_r;
  logic     hit_r;
  logic     fit;

  assign fit = occ_r && probe_in.valid && probe_in.rw <= row_r.space &&
               probe_in.rh <= row_r.tall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r         <= 1'b0;
      probe_r.valid <= 1'b0;
      hit_r         <= 1'b0;
    end else begin
      if (clr_all) occ_r <= 1'b0;
      else if (occ_set) occ_r <= 1'b1;
      probe_r.valid <= probe_in.valid;
      hit_r         <= probe_in.valid && (hit_in || fit);
    end
    probe_r.rw <= probe_in.rw;
    probe_r.rh <= probe_in.rh;
    if (wr_en) row_r <= wr_row;
    else if (upd_en) begin
      row_r.left_x <= row_r.left_x + upd_w;
      row_r.space  <= row_r.space - upd_w;
    end
  end

  assign mine      = probe_in.valid && fit && !hit_in;
  assign probe_out = probe_r;
  assign hit_out   = hit_r;
  assign row       = row_r;

endmodule

// File: hdl/atlas_shelf_allocator.sv
// ----------------------------------------------------------------------------
// atlas_shelf_allocator
// Shelf atlas allocator: first fit over a chain of row cells, new rows opened
// at the cursor; a new row that cannot fit doubles the narrower side, height on ties.
// ----------------------------------------------------------------------------
// channel | dir | payload   | handshake
// in      | in  | asa_in_t  | in_valid / in_stall
// out     | out | asa_out_t | out_valid / out_stall
// After acceptance the probe walks the cell chain in ST_SCAN; a fitting row
// then commits in ST_COMMIT, otherwise ST_GROW checks the new row and doubles
// the atlas until it fits, then ST_COMMIT commits and ST_OUT writes the row.
// Zero requests and oversized first requests answer the cycle after acceptance.
// Reset clears sizes, cursor and occupancy flags; row contents stay unset.
// The result is held in an output register until out_stall is low; in_stall
// stays high until it leaves.
// ----------------------------------------------------------------------------
module atlas_shelf_allocator
  import asa_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_SIDE = 16384
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  asa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output asa_out_t out_data
);

  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [16:0] SIDE  = 17'(MAX_SIDE);
  localparam logic [16:0] HALF  = 17'(MAX_SIDE / 2);
  localparam logic [CW-1:0] ROWS = CW'(MAX_ROWS);

  asa_state_t state_r, state_nxt;
  logic [16:0] w_r, h_r, cx_r, cy_r, w_nxt, h_nxt, cx_nxt, cy_nxt;
  logic [16:0] aw_r, ah_r, tall_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   tick_r, tick_nxt;
  logic [14:0] rw_r, rh_r;
  logic grew_r, grew_nxt, found_r, found_nxt, clr_r, clr_nxt;
  logic [IW-1:0] sel_r, sel_nxt;
  asa_out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  asa_probe_t probe [MAX_ROWS+1];
  logic       hit   [MAX_ROWS+1];
  logic       mine  [MAX_ROWS];
  asa_row_t   rows  [MAX_ROWS];
  logic       wr_en, upd_en;
  asa_row_t   wr_row;
  logic       probe_go;
  logic       clr_go;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign probe_go = (state_r == ST_SCAN) && (tick_r == '0);
  assign clr_go   = clr_r && (state_r == ST_COMMIT) && (res_nxt.status == STATUS_OK);

  assign probe[0] = '{valid: probe_go, rw: rw_r, rh: rh_r};
  assign hit[0]   = 1'b0;

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    asa_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .occ_set(wr_en && sel_r == IW'(g)),
      .clr_all(clr_go),
      .wr_en(wr_en && sel_r == IW'(g)),
      .wr_row(wr_row),
      .upd_en(upd_en && sel_r == IW'(g)),
      .upd_w(rw_r),
      .probe_in(probe[g]), .hit_in(hit[g]),
      .probe_out(probe[g+1]), .hit_out(hit[g+1]),
      .mine(mine[g]), .row(rows[g])
    );
  end

  logic mine_any;
  logic [IW-1:0] mine_idx;
  always_comb begin
    mine_any = 1'b0;
    mine_idx = '0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      if (mine[k]) begin
        mine_any = 1'b1;
        mine_idx = IW'(k);
      end
    end
  end

  logic fits;
  assign fits = (w_r >= cx_r) && ({2'b00, rw_r} <= w_r - cx_r) &&
                (h_r >= cy_r) && (tall_r <= h_r - cy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      aw_r        <= '0;
      ah_r        <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      clr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      clr_r       <= clr_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      if (state_r == ST_COMMIT && res_nxt.status == STATUS_OK &&
          res_nxt.place_width != '0) begin
        aw_r  <= w_r;
        ah_r  <= h_r;
        cnt_r <= cnt_nxt;
      end
    end
    w_r <= w_nxt; h_r <= h_nxt;
    grew_r <= grew_nxt; found_r <= found_nxt; sel_r <= sel_nxt;
    res_r <= res_nxt;
    if (accept) begin
      rw_r   <= in_data.req_width;
      rh_r   <= in_data.req_height;
      tall_r <= pow2_ceil(in_data.req_height);
    end
  end

  logic [16:0] cx_save_r, cy_save_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      cx_save_r <= cx_r;
      cy_save_r <= cy_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt = w_r; h_nxt = h_r; cx_nxt = cx_r; cy_nxt = cy_r;
    cnt_nxt = cnt_r; tick_nxt = tick_r; clr_nxt = clr_r;
    grew_nxt = grew_r; found_nxt = found_r; sel_nxt = sel_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en = 1'b0; upd_en = 1'b0;
    wr_row = '{left_x: cx_r[14:0], top_y: cy_r[14:0],
               space: 15'(w_r - cx_r), tall: tall_r[14:0]};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          grew_nxt = 1'b0; found_nxt = 1'b0; clr_nxt = 1'b0;
          tick_nxt = '0;
          if (in_data.req_width == '0 || in_data.req_height == '0) begin
            out_valid_nxt = 1'b1;
          end else if (aw_r == '0 || ah_r == '0) begin
            w_nxt = pow2_ceil(in_data.req_width);
            h_nxt = pow2_ceil(in_data.req_height);
            if (w_nxt > SIDE || h_nxt > SIDE) begin
              res_nxt.status = STATUS_SIDE;
              out_valid_nxt = 1'b1;
            end else state_nxt = ST_SCAN;
          end else begin
            w_nxt = aw_r; h_nxt = ah_r;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        tick_nxt = tick_r + 1'b1;
        if (mine_any) begin
          found_nxt = 1'b1;
          sel_nxt = mine_idx;
        end
        if (tick_r == (CW+1)'(MAX_ROWS)) begin
          cnt_nxt = cnt_r;
          state_nxt = (found_r || mine_any) ? ST_COMMIT : ST_GROW;
        end
      end
      ST_GROW: begin
        if (fits) state_nxt = ST_COMMIT;
        else if (w_r < h_r) begin
          if (w_r > HALF) begin
            res_nxt.status = STATUS_SIDE; state_nxt = ST_COMMIT;
          end else begin
            cx_nxt = w_r; cy_nxt = '0; w_nxt = w_r << 1;
            grew_nxt = 1'b1; clr_nxt = 1'b1;
          end
        end else begin
          if (h_r > HALF) begin
            res_nxt.status = STATUS_SIDE; state_nxt = ST_COMMIT;
          end else begin
            cx_nxt = '0; cy_nxt = h_r; h_nxt = h_r << 1;
            grew_nxt = 1'b1; clr_nxt = 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        cnt_nxt = clr_r ? '0 : cnt_r;
        if (res_r.status == STATUS_OK && !found_r && cnt_nxt >= ROWS)
          res_nxt.status = STATUS_FULL;
        if (res_nxt.status != STATUS_OK) begin
          res_nxt.atlas_width  = aw_r[14:0];
          res_nxt.atlas_height = ah_r[14:0];
          cx_nxt = cx_save_r; cy_nxt = cy_save_r;
          clr_nxt = 1'b0;
        end else if (found_r) begin
          res_nxt.place_x = rows[sel_r].left_x[13:0];
          res_nxt.place_y = rows[sel_r].top_y[13:0];
          res_nxt.place_height = rows[sel_r].tall;
          upd_en = 1'b1;
        end else begin
          sel_nxt = cnt_nxt[IW-1:0];
          res_nxt.place_x = cx_r[13:0];
          res_nxt.place_y = cy_r[13:0];
          res_nxt.place_height = tall_r[14:0];
          cnt_nxt = cnt_nxt + 1'b1;
          cy_nxt = cy_r + tall_r;
          found_nxt = 1'b1;
          state_nxt = ST_OUT;
        end
        if (res_nxt.status == STATUS_OK) begin
          res_nxt.place_width  = rw_r;
          res_nxt.atlas_width  = w_r[14:0];
          res_nxt.atlas_height = h_r[14:0];
          res_nxt.grew = grew_r;
        end
        if (state_nxt != ST_OUT) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        wr_row = '{left_x: 15'(cx_r + {2'b00, rw_r}), top_y: {1'b0, res_r.place_y},
                   space: 15'(w_r - cx_r - {2'b00, rw_r}), tall: tall_r[14:0]};
        wr_en = 1'b1;
        clr_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

// File: hdl/asa_checker.sv
// ----------------------------------------------------------------------------
// asa_checker
// Port-level checks for the shelf atlas allocator.
// ----------------------------------------------------------------------------
module asa_checker
  import asa_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input asa_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input asa_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |->
      out_data.place_width == '0 && !out_data.grew)
    else $error("error result carries placement");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

endmodule

bind atlas_shelf_allocator asa_checker u_asa_checker (.*);

// File: sim/atlas_shelf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atlas_shelf_checker
// Watches both channels of the shelf atlas allocator, predicts each placement
// from its own copy of the atlas and row store, and counts mismatches.
// ----------------------------------------------------------------------------
module atlas_shelf_checker
  import asa_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_SIDE = 16384
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  asa_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  asa_out_t out_data,
  output int       fail_count,
  output int       pending
);

  int unsigned atl_w, atl_h, cur_x, cur_y, n_rows;
  int unsigned shelf_x[MAX_ROWS];
  int unsigned shelf_y[MAX_ROWS];
  int unsigned shelf_space[MAX_ROWS];
  int unsigned shelf_tall[MAX_ROWS];
  asa_out_t placements[$];

  function automatic int unsigned ceil_pow2(int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  function automatic bit fits(int unsigned need, int unsigned size, int unsigned at);
    return size >= at && need <= size - at;
  endfunction

  task automatic place(input asa_in_t req);
    int unsigned rw, rh, w, h, cx, cy, cnt, sel, tall;
    logic [1:0] st;
    bit grew, found;
    asa_out_t r;
    rw = req.req_width;
    rh = req.req_height;
    w = atl_w; h = atl_h; cx = cur_x; cy = cur_y; cnt = n_rows;
    sel = 0; st = STATUS_OK; grew = 0; found = 0;
    r = '0;
    if (rw == 0 || rh == 0) begin
      placements.push_back(r);
      return;
    end
    if (w == 0 || h == 0) begin
      w = ceil_pow2(rw);
      h = ceil_pow2(rh);
      if (w > MAX_SIDE || h > MAX_SIDE) st = STATUS_SIDE;
    end
    if (st == STATUS_OK) begin
      for (int i = 0; i < cnt; i++) begin
        if (!found && rw <= shelf_space[i] && rh <= shelf_tall[i]) begin
          sel = i;
          found = 1;
        end
      end
    end
    if (st == STATUS_OK && !found) begin
      tall = ceil_pow2(rh);
      while (st == STATUS_OK && (!fits(rw, w, cx) || !fits(tall, h, cy))) begin
        if (w < h) begin
          if (w > MAX_SIDE / 2) st = STATUS_SIDE;
          else begin cx = w; cy = 0; w = w * 2; end
        end else begin
          if (h > MAX_SIDE / 2) st = STATUS_SIDE;
          else begin cx = 0; cy = h; h = h * 2; end
        end
        if (st == STATUS_OK) begin
          cnt = 0;
          grew = 1;
        end
      end
      if (st == STATUS_OK && cnt >= MAX_ROWS) st = STATUS_FULL;
      if (st == STATUS_OK) begin
        sel = cnt;
        shelf_x[sel] = cx;
        shelf_y[sel] = cy;
        shelf_space[sel] = w - cx;
        shelf_tall[sel] = tall;
        cnt++;
        cy += tall;
      end
    end
    if (st != STATUS_OK) begin
      r.atlas_width = atl_w[14:0];
      r.atlas_height = atl_h[14:0];
      r.status = st;
      placements.push_back(r);
      return;
    end
    atl_w = w; atl_h = h; cur_x = cx; cur_y = cy; n_rows = cnt;
    r.place_x = shelf_x[sel][13:0];
    r.place_y = shelf_y[sel][13:0];
    r.place_width = rw[14:0];
    r.place_height = shelf_tall[sel][14:0];
    r.atlas_width = w[14:0];
    r.atlas_height = h[14:0];
    r.grew = grew;
    r.status = STATUS_OK;
    shelf_x[sel] += rw;
    shelf_space[sel] -= rw;
    placements.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      atl_w = 0; atl_h = 0; cur_x = 0; cur_y = 0; n_rows = 0;
      fail_count = 0;
      placements.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (placements.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          if (out_data !== placements[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", placements[0], out_data);
          end
          void'(placements.pop_front());
        end
      end
      if (in_valid && !in_stall) place(in_data);
    end
    pending = placements.size();
  end

endmodule

// File: sim/tb_atlas_shelf_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atlas_shelf_allocator
// Drives directed and random rectangle requests into the shelf allocator with
// bursty input and patterned output stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_atlas_shelf_allocator;
  import asa_pkg::*;

  localparam int LIMIT = 1500000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  asa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  asa_out_t out_data;
  int       fail_count, pending;
  int       cycles = 0;
  int       stall_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  atlas_shelf_allocator u_top (.*);

  atlas_shelf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[atlas_shelf_allocator] ERROR");
      $finish;
    end
  end

  // stall pattern: quiet stretches, periodic stalls, random stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 2000) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= (stall_phase % 7) < 3;
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [14:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 15'd0;
      1: return 15'd16384;
      2: return 15'($urandom_range(8193, 32767));
      3, 4: return 15'($urandom_range(1, 4096));
      default: return 15'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic send(input logic [14:0] w, input logic [14:0] h);
    in_data <= '{req_width: w, req_height: h};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 80) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    int left;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(15'd0, 15'd5);
    send(15'd20000, 15'd3);
    send(15'd3, 15'd5);
    send(15'd3, 15'd0);
    send(15'd1, 15'd1);
    send(15'd4, 15'd8);
    send(15'd2, 15'd3);
    send(15'd9, 15'd1);
    send(15'd16384, 15'd16384);
    send(15'd32767, 15'd32767);
    send(15'd16384, 15'd1);
    send(15'd1, 15'd16384);
    send(15'd8191, 15'd8191);
    for (int i = 0; i < 70; i++) send(15'd1, 15'd1);
    left = 0;
    for (int i = 0; i < 900; i++) begin
      if (left == 0) begin
        gap();
        left = $urandom_range(1, 40);
      end
      left--;
      send(rand_dim(), rand_dim());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[atlas_shelf_allocator] OK");
    else $display("[atlas_shelf_allocator] ERROR");
    $finish;
  end

endmodule
